@@ sv/tupd_pkg.sv @@
// Package for the tile-update packet decoder: phase codes, result struct,
// status struct and tdata layout. Depends on nothing.
`default_nettype none

package tupd_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CoordW     = 16;
  localparam int unsigned LevelW     = 2;
  localparam int unsigned CountW     = 5;
  localparam int unsigned NibW       = 4;
  localparam int unsigned MTdataW    = 72;
  localparam logic [ByteW-1:0] TypeNone = 8'hff;

  typedef enum logic [9:0] {
    PH_X_FIRST = 10'b00_0000_0001,
    PH_X_LOW   = 10'b00_0000_0010,
    PH_Z_FIRST = 10'b00_0000_0100,
    PH_Z_LOW   = 10'b00_0000_1000,
    PH_HEADER  = 10'b00_0001_0000,
    PH_POS_HI  = 10'b00_0010_0000,
    PH_POS_LO  = 10'b00_0100_0000,
    PH_HEIGHT  = 10'b00_1000_0000,
    PH_TYPE    = 10'b01_0000_0000,
    PH_DATA    = 10'b10_0000_0000
  } phase_e;

  typedef struct packed {
    logic              is_tile;
    logic [CoordW-1:0] chunk_x;
    logic [CoordW-1:0] chunk_z;
    logic [LevelW-1:0] level_index;
    logic [CountW-1:0] tile_count;
    logic [NibW-1:0]   tile_x;
    logic [NibW-1:0]   tile_z;
    logic [ByteW-1:0]  tile_y;
    logic [ByteW-1:0]  block_type;
    logic [ByteW-1:0]  block_data;
    logic              last_item;
  } result_t;

  typedef struct packed {
    logic              at_start;
    logic [CountW-1:0] entries_left;
  } status_t;

endpackage : tupd_pkg

`default_nettype wire

@@ sv/tile_update_packet_decoder.sv @@
// Tile-update packet decoder, top level. Uses tupd_pkg, tupd_parser, tupd_out_reg.
// Throughput: one input byte per cycle, sustained, while the sink keeps up.
// Output: a result beat is registered and appears in the cycle after the byte that closes it.
// Only the single result register lies between; the parser forms each result combinationally.
// Reset (rst_ni low, asynchronous): start of a packet, narrow coordinates,
// result register empty.
`default_nettype none

module tile_update_packet_decoder import tupd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration: wide_coordinates
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  // byte stream in
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [ByteW-1:0]   s_axis_tdata_i,   // [7:0] in_byte
  // result beats out
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  // [15:0] chunk_x, [31:16] chunk_z, [33:32] level_index, [38:34] tile_count,
  // [42:39] tile_x, [46:43] tile_z, [54:47] tile_y, [62:55] block_type,
  // [70:63] block_data, [71] zero
  output logic [MTdataW-1:0]      m_axis_tdata_o,
  output logic                    m_axis_tuser_o,   // [0] is_tile
  output logic                    m_axis_tlast_o    // last_item
);

  logic    wide_q;
  logic    accept;
  logic    emit;
  logic    can_load;
  result_t result;
  result_t out_result;
  status_t status;

  // Configuration register: the user must write it only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q <= 1'b0;
    end else if (cfg_we_i) begin
      wide_q <= cfg_wdata_i;
    end
  end

  // Take a byte whenever the result register can absorb a result this cycle;
  // a waiting result does not block the stream if the sink drains it now.
  assign s_axis_tready_o = can_load;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  tupd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wide_i   (wide_q),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .emit_o   (emit),
    .result_o (result),
    .status_o (status)
  );

  tupd_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept && emit),
    .result_i   (result),
    .ready_i    (m_axis_tready_i),
    .can_load_o (can_load),
    .valid_o    (m_axis_tvalid_o),
    .result_o   (out_result)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata_o = {1'b0,
                           out_result.block_data,
                           out_result.block_type,
                           out_result.tile_y,
                           out_result.tile_z,
                           out_result.tile_x,
                           out_result.tile_count,
                           out_result.level_index,
                           out_result.chunk_z,
                           out_result.chunk_x};
  assign m_axis_tuser_o = out_result.is_tile;
  assign m_axis_tlast_o = out_result.last_item;

  // A header result ends the packet exactly when its entry count is zero.
  a_header_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |->
      (m_axis_tlast_o == (m_axis_tdata_o[38:34] == '0)))
    else $error("header tlast does not match entry count");

  // At a packet boundary no entries may be outstanding.
  a_start_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.at_start |-> (status.entries_left == '0))
    else $error("entries left at packet start");

  // A result that closes a packet returns the parser to a packet boundary.
  a_last_to_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && emit && result.last_item) |=> status.at_start)
    else $error("parser not at packet start after last result");

  // A header result carries block type none and no block data.
  a_header_type : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |->
      (m_axis_tdata_o[62:55] == TypeNone && m_axis_tdata_o[70:63] == '0))
    else $error("header result carries tile payload");

endmodule : tile_update_packet_decoder

`default_nettype wire

@@ sv/tupd_parser.sv @@
// Packet parser: phase state machine and per-packet field registers.
// Consumes one byte per accepted beat; depends on tupd_pkg.
`default_nettype none

module tupd_parser import tupd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wide_i,
  input  wire logic             accept_i,
  input  wire logic [ByteW-1:0] byte_i,
  output logic                  emit_o,
  output result_t               result_o,
  output status_t               status_o
);

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  hi_q, hi_d;
  logic [CoordW-1:0] cx_q, cx_d, cz_q, cz_d;
  logic              zero_q, zero_d;
  logic [LevelW-1:0] level_q, level_d;
  logic [CountW-1:0] count_q, count_d, left_q, left_d;
  logic [ByteW-1:0]  type_q, type_d, pos_q, pos_d, height_q, height_d;
  logic              follows_q, follows_d;

  logic [CoordW-1:0] sext_b;
  logic [CountW-1:0] left_dec;
  logic              emit_entry;
  logic [ByteW-1:0]  entry_data;

  assign sext_b   = {{(CoordW-ByteW){byte_i[ByteW-1]}}, byte_i};
  assign left_dec = left_q - CountW'(1);

  always_comb begin
    phase_d    = phase_q;
    hi_d       = hi_q;
    cx_d       = cx_q;
    cz_d       = cz_q;
    zero_d     = zero_q;
    level_d    = level_q;
    count_d    = count_q;
    left_d     = left_q;
    type_d     = type_q;
    pos_d      = pos_q;
    height_d   = height_q;
    follows_d  = follows_q;
    emit_o     = 1'b0;
    emit_entry = 1'b0;
    entry_data = '0;
    result_o   = '0;
    case (phase_q)
      PH_X_LOW: begin
        cx_d    = {hi_q, byte_i};
        phase_d = PH_Z_FIRST;
      end
      PH_Z_FIRST: begin
        if (wide_i) begin
          hi_d    = byte_i;
          phase_d = PH_Z_LOW;
        end else begin
          cz_d    = sext_b;
          phase_d = PH_HEADER;
        end
      end
      PH_Z_LOW: begin
        cz_d    = {hi_q, byte_i};
        phase_d = PH_HEADER;
      end
      PH_HEADER: begin
        zero_d               = byte_i[7];
        level_d              = byte_i[6:5];
        count_d              = byte_i[4:0];
        left_d               = byte_i[4:0];
        type_d               = TypeNone;
        emit_o               = 1'b1;
        result_o.is_tile     = 1'b0;
        result_o.chunk_x     = cx_q;
        result_o.chunk_z     = cz_q;
        result_o.level_index = byte_i[6:5];
        result_o.tile_count  = byte_i[4:0];
        result_o.block_type  = TypeNone;
        result_o.last_item   = (byte_i[4:0] == '0);
        phase_d              = (byte_i[4:0] == '0) ? PH_X_FIRST : PH_POS_HI;
      end
      PH_POS_HI: begin
        pos_d   = byte_i;
        phase_d = PH_POS_LO;
      end
      PH_POS_LO: begin
        follows_d = byte_i[7];
        phase_d   = PH_HEIGHT;
      end
      PH_HEIGHT: begin
        height_d = byte_i;
        if (follows_q) begin
          phase_d = PH_TYPE;
        end else if (!zero_q) begin
          phase_d = PH_DATA;
        end else begin
          emit_entry = 1'b1;
        end
      end
      PH_TYPE: begin
        type_d = byte_i;
        if (!zero_q) begin
          phase_d = PH_DATA;
        end else begin
          emit_entry = 1'b1;
        end
      end
      PH_DATA: begin
        emit_entry = 1'b1;
        entry_data = byte_i;
      end
      default: begin
        if (wide_i) begin
          hi_d    = byte_i;
          phase_d = PH_X_LOW;
        end else begin
          cx_d    = sext_b;
          phase_d = PH_Z_FIRST;
        end
      end
    endcase

    // Entry results take height and type from this beat when it carries them.
    if (emit_entry) begin
      emit_o               = 1'b1;
      result_o.is_tile     = 1'b1;
      result_o.chunk_x     = cx_q;
      result_o.chunk_z     = cz_q;
      result_o.level_index = level_q;
      result_o.tile_count  = count_q;
      result_o.tile_x      = pos_q[7:4];
      result_o.tile_z      = pos_q[3:0];
      result_o.tile_y      = height_d;
      result_o.block_type  = type_d;
      result_o.block_data  = entry_data;
      result_o.last_item   = (left_q == CountW'(1));
      left_d               = left_dec;
      phase_d              = (left_dec == '0) ? PH_X_FIRST : PH_POS_HI;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_X_FIRST;
      hi_q      <= '0;
      cx_q      <= '0;
      cz_q      <= '0;
      zero_q    <= 1'b0;
      level_q   <= '0;
      count_q   <= '0;
      left_q    <= '0;
      type_q    <= TypeNone;
      pos_q     <= '0;
      follows_q <= 1'b0;
      height_q  <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      hi_q      <= hi_d;
      cx_q      <= cx_d;
      cz_q      <= cz_d;
      zero_q    <= zero_d;
      level_q   <= level_d;
      count_q   <= count_d;
      left_q    <= left_d;
      type_q    <= type_d;
      pos_q     <= pos_d;
      follows_q <= follows_d;
      height_q  <= height_d;
    end
  end

  assign status_o.at_start     = (phase_q == PH_X_FIRST);
  assign status_o.entries_left = left_q;

endmodule : tupd_parser

`default_nettype wire

@@ sv/tupd_out_reg.sv @@
// Result register for the decoder: holds one result beat until the sink
// takes it, and refills in the same cycle. Depends on tupd_pkg.
`default_nettype none

module tupd_out_reg import tupd_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t result_i,
  input  wire logic    ready_i,
  output logic         can_load_o,
  output logic         valid_o,
  output result_t      result_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign can_load_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;

endmodule : tupd_out_reg

`default_nettype wire

@@ verif/tb_tile_update_packet_decoder.sv @@
// Self-checking testbench for tile_update_packet_decoder: streams packet bytes
// with random gaps and sink stalls, and predicts every result beat in-line.
// Depends on tupd_pkg and the decoder RTL only.

module tb_tile_update_packet_decoder import tupd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let the block settle once nothing is pending.
  localparam int unsigned SettleCycles = 4;
  // Cycles without any accepted beat, on either side, before giving up.
  localparam int unsigned StallLimit   = 4000;
  // Sink hold-off used to back the block up into its input.
  localparam int unsigned LongHold     = 300;
  localparam int unsigned RandomPhases = 6;
  localparam int unsigned PhaseBytes   = 250;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic               cfg_wdata_i     = 1'b0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [ByteW-1:0]   s_axis_tdata_i  = '0;   // [7:0] in_byte
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  // [15:0] chunk_x, [31:16] chunk_z, [33:32] level_index, [38:34] tile_count,
  // [42:39] tile_x, [46:43] tile_z, [54:47] tile_y, [62:55] block_type,
  // [70:63] block_data, [71] zero
  logic [MTdataW-1:0] m_axis_tdata_o;
  logic               m_axis_tuser_o;         // [0] is_tile
  logic               m_axis_tlast_o;         // last_item

  tile_update_packet_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder prediction: a private copy of the parse state, advanced once per
  // accepted byte. Reset values match the block's reset.
  // ---------------------------------------------------------------------------
  bit                wide_coords = 1'b0;
  phase_e            parse_ph    = PH_X_FIRST;
  logic [ByteW-1:0]  word_hi     = '0;
  logic [CoordW-1:0] cur_x       = '0;
  logic [CoordW-1:0] cur_z       = '0;
  logic              no_data     = 1'b0;
  logic [LevelW-1:0] cur_level   = '0;
  logic [CountW-1:0] cur_count   = '0;
  logic [CountW-1:0] tiles_to_go = '0;
  logic [ByteW-1:0]  cur_type    = TypeNone;
  logic [ByteW-1:0]  pos_byte    = '0;
  logic              type_next   = 1'b0;
  logic [ByteW-1:0]  height      = '0;

  // Results still owed by the block, oldest first.
  result_t pending_updates[$];

  int unsigned bytes_sent = 0;
  int unsigned mismatches = 0;

  // Random idling on both sides; cleared for the closing stretch of the run.
  bit          idle_on   = 1'b1;
  // Set by a test to make the sink hold off for that many cycles.
  int unsigned sink_hold = 0;

  // Packet under construction for the random traffic.
  logic [ByteW-1:0] pkt_bytes[$];

  // Close one tile entry: queue its result and step to the next entry or packet.
  function automatic void emit_tile(input logic [ByteW-1:0] data);
    result_t r;
    r             = '0;
    r.is_tile     = 1'b1;
    r.chunk_x     = cur_x;
    r.chunk_z     = cur_z;
    r.level_index = cur_level;
    r.tile_count  = cur_count;
    r.tile_x      = pos_byte[7:4];
    r.tile_z      = pos_byte[3:0];
    r.tile_y      = height;
    r.block_type  = cur_type;
    r.block_data  = data;
    r.last_item   = (tiles_to_go == 1);
    pending_updates.push_back(r);
    tiles_to_go = tiles_to_go - 1'b1;
    parse_ph    = (tiles_to_go == 0) ? PH_X_FIRST : PH_POS_HI;
  endfunction

  function automatic void decode_byte(input logic [ByteW-1:0] b);
    result_t r;
    r = '0;
    case (parse_ph)
      PH_X_LOW: begin
        cur_x    = {word_hi, b};
        parse_ph = PH_Z_FIRST;
      end
      PH_Z_FIRST: begin
        // width is sampled at the first byte of each coordinate
        if (wide_coords) begin
          word_hi  = b;
          parse_ph = PH_Z_LOW;
        end else begin
          cur_z    = {{8{b[7]}}, b};
          parse_ph = PH_HEADER;
        end
      end
      PH_Z_LOW: begin
        cur_z    = {word_hi, b};
        parse_ph = PH_HEADER;
      end
      PH_HEADER: begin
        no_data       = b[7];
        cur_level     = b[6:5];
        cur_count     = b[4:0];
        tiles_to_go   = b[4:0];
        cur_type      = TypeNone;
        r.is_tile     = 1'b0;
        r.chunk_x     = cur_x;
        r.chunk_z     = cur_z;
        r.level_index = cur_level;
        r.tile_count  = cur_count;
        r.block_type  = TypeNone;
        r.last_item   = (cur_count == 0);
        pending_updates.push_back(r);
        parse_ph = (cur_count == 0) ? PH_X_FIRST : PH_POS_HI;
      end
      PH_POS_HI: begin
        pos_byte = b;
        parse_ph = PH_POS_LO;
      end
      PH_POS_LO: begin
        // only bit 7 matters here
        type_next = b[7];
        parse_ph  = PH_HEIGHT;
      end
      PH_HEIGHT: begin
        height = b;
        if (type_next) parse_ph = PH_TYPE;
        else if (!no_data) parse_ph = PH_DATA;
        else emit_tile('0);
      end
      PH_TYPE: begin
        cur_type = b;
        if (!no_data) parse_ph = PH_DATA;
        else emit_tile('0);
      end
      PH_DATA: emit_tile(b);
      default: begin
        if (wide_coords) begin
          word_hi  = b;
          parse_ph = PH_X_LOW;
        end else begin
          cur_x    = {{8{b[7]}}, b};
          parse_ph = PH_Z_FIRST;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stream driver
  // ---------------------------------------------------------------------------

  // Offer one byte and hold it until accepted. Leave tvalid high for a
  // back-to-back beat unless a random gap follows.
  task automatic put_byte(input logic [ByteW-1:0] b);
    s_axis_tdata_i  <= b;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    decode_byte(b);
    bytes_sent++;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // Drop tvalid and wait until every owed result has come out.
  task automatic drain();
    if (s_axis_tvalid_i) s_axis_tvalid_i <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk_i);
  endtask

  // Write wide_coordinates with the block idle.
  task automatic set_wide(input bit v);
    drain();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    wide_coords = v;
    cfg_we_i   <= 1'b0;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++) put_byte(pkt_bytes[i]);
  endtask

  // Feed random bytes until the parser is back at a packet boundary.
  task automatic realign();
    while (parse_ph != PH_X_FIRST) put_byte($urandom_range(0, 255));
  endtask

  // Build one well-formed packet with random content; mostly short ones.
  function automatic void build_packet(input bit wide_fmt, input int forced_count);
    logic [31:0]       rnd;
    logic [ByteW-1:0]  hdr;
    logic [ByteW-1:0]  pos_lo;
    int unsigned       sel;
    int unsigned       n;
    pkt_bytes.delete();
    rnd = $urandom;
    if (wide_fmt) begin
      pkt_bytes.push_back(rnd[15:8]);
      pkt_bytes.push_back(rnd[7:0]);
      pkt_bytes.push_back(rnd[31:24]);
      pkt_bytes.push_back(rnd[23:16]);
    end else begin
      pkt_bytes.push_back(rnd[7:0]);
      pkt_bytes.push_back(rnd[23:16]);
    end
    sel = $urandom_range(0, 99);
    if (forced_count >= 0) n = forced_count;
    else if (sel < 70) n = $urandom_range(0, 3);
    else if (sel < 95) n = $urandom_range(4, 10);
    else n = $urandom_range(11, 31);
    rnd = $urandom;
    hdr = {rnd[7:5], 5'(n)};
    pkt_bytes.push_back(hdr);
    for (int i = 0; i < n; i++) begin
      rnd    = $urandom;
      pos_lo = rnd[15:8];
      pkt_bytes.push_back(rnd[7:0]);
      pkt_bytes.push_back(pos_lo);
      pkt_bytes.push_back(rnd[23:16]);
      if (pos_lo[7]) pkt_bytes.push_back(rnd[31:24]);
      if (!hdr[7]) pkt_bytes.push_back($urandom_range(0, 255));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sink: random stall bursts, or a long hold-off on request, or always ready.
  // ---------------------------------------------------------------------------
  initial begin : sink_driver
    int unsigned n;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        n         = sink_hold;
        sink_hold = 0;
        m_axis_tready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted beat against the oldest prediction.
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : beat_checker
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_updates.size() == 0) begin
        $error("result beat with no result expected (tdata 0x%0h)", m_axis_tdata_o);
        mismatches++;
      end else begin
        want = pending_updates.pop_front();
        check_field("is_tile",     want.is_tile,     m_axis_tuser_o);
        check_field("chunk_x",     want.chunk_x,     m_axis_tdata_o[15:0]);
        check_field("chunk_z",     want.chunk_z,     m_axis_tdata_o[31:16]);
        check_field("level_index", want.level_index, m_axis_tdata_o[33:32]);
        check_field("tile_count",  want.tile_count,  m_axis_tdata_o[38:34]);
        check_field("tile_x",      want.tile_x,      m_axis_tdata_o[42:39]);
        check_field("tile_z",      want.tile_z,      m_axis_tdata_o[46:43]);
        check_field("tile_y",      want.tile_y,      m_axis_tdata_o[54:47]);
        check_field("block_type",  want.block_type,  m_axis_tdata_o[62:55]);
        check_field("block_data",  want.block_data,  m_axis_tdata_o[70:63]);
        check_field("last_item",   want.last_item,   m_axis_tlast_o);
      end
    end
  end

  // Watchdog: count cycles in which neither side moves a beat.
  int unsigned stall_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Narrow coordinates at both sign extremes, header-only packet.
  task automatic test_narrow_extremes();
    put_byte(8'h80);   // x = -128
    put_byte(8'h7f);   // z = +127
    put_byte(8'h00);   // no entries: header is the last beat
  endtask

  // All-zero data flag: entries close on height or type, low bits of the
  // second position byte ignored, type stays 255 until one is sent.
  task automatic test_all_zero_entries();
    put_byte(8'hff);   // x = -1
    put_byte(8'h00);   // z = 0
    put_byte(8'he2);   // all-zero, level 3, two entries
    put_byte(8'hff);   // tile x 15, z 15
    put_byte(8'h7f);   // no type, junk low bits
    put_byte(8'hff);   // height
    put_byte(8'h00);
    put_byte(8'h80);   // type follows
    put_byte(8'h00);
    put_byte(8'h00);   // type 0
  endtask

  // Wide coordinates at both extremes, entry with type and data byte.
  task automatic test_wide_entry_with_data();
    set_wide(1'b1);
    put_byte(8'h80);
    put_byte(8'h00);   // x = -32768
    put_byte(8'h7f);
    put_byte(8'hff);   // z = +32767
    put_byte(8'h41);   // level 2, one entry, data present
    put_byte(8'h5a);
    put_byte(8'h80);
    put_byte(8'h12);
    put_byte(8'h34);
    put_byte(8'hff);
  endtask

  // Width change between the two bytes of a coordinate: the low byte is still
  // taken; the next coordinate follows the new setting.
  task automatic test_register_change_midword();
    put_byte(8'hfe);   // x high byte, wide
    set_wide(1'b0);
    put_byte(8'hdc);   // x low byte
    put_byte(8'h85);   // z narrow
    put_byte(8'h20);
    put_byte(8'h7f);   // x narrow
    set_wide(1'b1);
    put_byte(8'h80);   // z is now a word
    put_byte(8'h01);
    put_byte(8'h60);
  endtask

  // Hold the sink off while a full 31-entry packet streams in, so the block
  // backs up and stalls its input; then pause until everything is out.
  task automatic test_backpressure();
    drain();
    sink_hold = LongHold;
    build_packet(wide_coords, 31);
    send_packet();
    drain();
  endtask

  // Mostly well-formed packets, some cut short, some plain noise; the width
  // can change between phases and the last phase runs without idling.
  task automatic test_random_traffic();
    int unsigned target;
    int unsigned kind;
    bit          w;
    for (int p = 0; p < RandomPhases; p++) begin
      if (p == 0) w = 1'b0;
      else if (p == 1) w = 1'b1;
      else w = $urandom_range(0, 1);
      set_wide(w);
      if (p == RandomPhases - 1) idle_on = 1'b0;
      target = bytes_sent + PhaseBytes;
      while (bytes_sent < target) begin
        kind = $urandom_range(0, 99);
        build_packet(wide_coords, -1);
        if (kind < 85) begin
          send_packet();
        end else if (kind < 93) begin
          for (int i = 0; i < $urandom_range(1, pkt_bytes.size() - 1); i++)
            put_byte(pkt_bytes[i]);
          realign();
        end else begin
          repeat ($urandom_range(1, 6)) put_byte($urandom_range(0, 255));
          realign();
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_narrow_extremes();
    test_all_zero_entries();
    test_wide_entry_with_data();
    test_register_change_midword();
    test_backpressure();
    test_random_traffic();

    // Wait out the last results, then give stray beats a chance to show.
    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
